// File: hw/rtl/xenc_pkg.sv
// Shared types and constants for the x86-64 instruction encoder.
// No dependencies; imported by every encoder module.
package xenc_pkg;

    localparam int MaxBytes = 10;
    localparam int LenW     = $clog2(MaxBytes + 1);
    localparam int IdxW     = $clog2(MaxBytes);

    typedef enum logic [5:0] {
        FORM_PUSH     = 6'd0,
        FORM_POP      = 6'd1,
        FORM_MOV_RR   = 6'd2,
        FORM_MOV_RI64 = 6'd3,
        FORM_MOV_RM   = 6'd4,
        FORM_MOV_MR   = 6'd5,
        FORM_LEA_SIB  = 6'd6,
        FORM_LEA      = 6'd7,
        FORM_ZERO     = 6'd8,
        FORM_SHR_I    = 6'd9,
        FORM_SHL_I    = 6'd10,
        FORM_ADD_RR   = 6'd11,
        FORM_ADD_I8   = 6'd12,
        FORM_SUB_RR   = 6'd13,
        FORM_AND_RR   = 6'd14,
        FORM_AND_I32  = 6'd15,
        FORM_OR_RR    = 6'd16,
        FORM_XOR_RR   = 6'd17,
        FORM_SHL_CL   = 6'd18,
        FORM_SHR_CL   = 6'd19,
        FORM_IMUL     = 6'd20,
        FORM_CQO      = 6'd21,
        FORM_IDIV     = 6'd22,
        FORM_CALL     = 6'd23,
        FORM_RET      = 6'd24,
        FORM_LEAVE    = 6'd25,
        FORM_SUB_RSP  = 6'd26,
        FORM_ADD_RSP  = 6'd27,
        FORM_SYSCALL  = 6'd28,
        FORM_JMP      = 6'd29,
        FORM_JCOND    = 6'd30,
        FORM_CMP_I8   = 6'd31,
        FORM_TEST_RR  = 6'd32,
        FORM_CMP_RR   = 6'd33,
        FORM_SETCOND  = 6'd34,
        FORM_MOVZX    = 6'd35,
        FORM_LOAD_B   = 6'd36,
        FORM_STORE_B  = 6'd37,
        FORM_INC      = 6'd38
    } form_t;

    // Encoded instruction: byte 0 goes out first.
    typedef struct packed {
        logic [MaxBytes-1:0][7:0] bytes;
        logic [LenW-1:0]          len;
    } xenc_item_t;

    // Queue status seen by the front end and the back end.
    typedef struct packed {
        logic full;
        logic valid;
    } xenc_qstat_t;

endpackage

// File: hw/rtl/xenc_front.sv
// Front end: accepts instruction requests, encodes them into a byte list.
// Depends on xenc_pkg.
module xenc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [5:0]            req_type,
    input  logic [3:0]            reg_a,
    input  logic [3:0]            reg_b,
    input  logic [3:0]            base_reg,
    input  logic [3:0]            index_reg,
    input  logic [3:0]            scale,
    input  logic signed [31:0]    disp,
    input  logic [63:0]           imm,
    input  logic [3:0]            cond,
    input  xenc_pkg::xenc_qstat_t qstat,
    output logic                  push,
    output xenc_pkg::xenc_item_t  push_item
);
    import xenc_pkg::*;

    localparam logic [7:0] OpPush    = 8'h50;
    localparam logic [7:0] OpPop     = 8'h58;
    localparam logic [7:0] OpMovImm  = 8'hB8;
    localparam logic [7:0] OpMovSt   = 8'h89;
    localparam logic [7:0] OpMovLd   = 8'h8B;
    localparam logic [7:0] OpLea     = 8'h8D;
    localparam logic [7:0] OpShiftI  = 8'hC1;
    localparam logic [7:0] OpShiftCl = 8'hD3;
    localparam logic [7:0] OpImul2   = 8'hAF;
    localparam logic [7:0] OpJmp     = 8'hE9;
    localparam logic [7:0] OpEsc     = 8'h0F;
    localparam logic [7:0] OpXor     = 8'h31;
    localparam logic [7:0] OpGrp1I8  = 8'h83;
    localparam logic [7:0] OpGrp1I32 = 8'h81;
    localparam logic [7:0] OpGrp5    = 8'hFF;
    localparam logic [7:0] RexW      = 8'h48;
    localparam logic [7:0] RexB      = 8'h41;
    localparam logic [7:0] SibRsp    = 8'h24;

    logic       valid_reg, valid_next;
    xenc_item_t item_reg, item_next;
    xenc_item_t enc;
    logic       accept;

    function automatic logic [7:0] rex_b(input logic w, input logic r,
                                         input logic x, input logic b);
        return {4'h4, w, r, x, b};
    endfunction

    function automatic logic [7:0] modrm_b(input logic [1:0] md, input logic [2:0] rg,
                                           input logic [2:0] rm);
        return {md, rg, rm};
    endfunction

    always_comb
    begin
        logic [3:0] r;
        logic [1:0] ss;
        enc = '0;
        r   = 4'd0;
        ss  = 2'd0;
        case (form_t'(req_type))
            FORM_PUSH, FORM_POP:
            begin
                if (reg_a[3])
                begin
                    enc.bytes[0] = RexB;
                    enc.bytes[1] = ((req_type == FORM_PUSH) ? OpPush : OpPop)
                                   + {5'd0, reg_a[2:0]};
                    enc.len = LenW'(2);
                end
                else
                begin
                    enc.bytes[0] = ((req_type == FORM_PUSH) ? OpPush : OpPop)
                                   + {5'd0, reg_a[2:0]};
                    enc.len = LenW'(1);
                end
            end
            FORM_MOV_RR, FORM_ADD_RR, FORM_SUB_RR, FORM_AND_RR, FORM_OR_RR,
            FORM_XOR_RR, FORM_TEST_RR, FORM_CMP_RR:
            begin
                enc.bytes[0] = rex_b(1'b1, reg_b[3], 1'b0, reg_a[3]);
                case (form_t'(req_type))
                    FORM_MOV_RR:  enc.bytes[1] = OpMovSt;
                    FORM_ADD_RR:  enc.bytes[1] = 8'h01;
                    FORM_SUB_RR:  enc.bytes[1] = 8'h29;
                    FORM_AND_RR:  enc.bytes[1] = 8'h21;
                    FORM_OR_RR:   enc.bytes[1] = 8'h09;
                    FORM_XOR_RR:  enc.bytes[1] = OpXor;
                    FORM_TEST_RR: enc.bytes[1] = 8'h85;
                    default:      enc.bytes[1] = 8'h39;
                endcase
                enc.bytes[2] = modrm_b(2'd3, reg_b[2:0], reg_a[2:0]);
                enc.len = LenW'(3);
            end
            FORM_MOV_RI64:
            begin
                if (imm == 64'd0)
                begin
                    // zero immediate: xor A,A is shorter
                    enc.bytes[0] = rex_b(1'b1, reg_a[3], 1'b0, reg_a[3]);
                    enc.bytes[1] = OpXor;
                    enc.bytes[2] = modrm_b(2'd3, reg_a[2:0], reg_a[2:0]);
                    enc.len = LenW'(3);
                end
                else
                begin
                    enc.bytes[0]   = rex_b(1'b1, 1'b0, 1'b0, reg_a[3]);
                    enc.bytes[1]   = OpMovImm + {5'd0, reg_a[2:0]};
                    enc.bytes[9:2] = imm;
                    enc.len = LenW'(10);
                end
            end
            FORM_MOV_RM, FORM_MOV_MR:
            begin
                r = (req_type == FORM_MOV_RM) ? reg_a : reg_b;
                enc.bytes[0] = rex_b(1'b1, r[3], 1'b0, base_reg[3]);
                enc.bytes[1] = (req_type == FORM_MOV_RM) ? OpMovLd : OpMovSt;
                enc.bytes[2] = modrm_b(2'd2, r[2:0], base_reg[2:0]);
                if (base_reg[2:0] == 3'd4)
                begin
                    enc.bytes[3]   = SibRsp;
                    enc.bytes[7:4] = disp;
                    enc.len = LenW'(8);
                end
                else
                begin
                    enc.bytes[6:3] = disp;
                    enc.len = LenW'(7);
                end
            end
            FORM_LEA_SIB, FORM_LEA:
            begin
                if (req_type == FORM_LEA_SIB)
                begin
                    r = index_reg;
                    case (scale)
                        4'd2:    ss = 2'd1;
                        4'd4:    ss = 2'd2;
                        4'd8:    ss = 2'd3;
                        default: ss = 2'd0;
                    endcase
                end
                else
                begin
                    r  = 4'd4;
                    ss = 2'd0;
                end
                enc.bytes[0]   = rex_b(1'b1, reg_a[3], r[3], base_reg[3]);
                enc.bytes[1]   = OpLea;
                enc.bytes[2]   = modrm_b(2'd2, reg_a[2:0], 3'd4);
                enc.bytes[3]   = {ss, r[2:0], base_reg[2:0]};
                enc.bytes[7:4] = disp;
                enc.len = LenW'(8);
            end
            FORM_ZERO:
            begin
                enc.bytes[0] = rex_b(1'b1, reg_a[3], 1'b0, reg_a[3]);
                enc.bytes[1] = OpXor;
                enc.bytes[2] = modrm_b(2'd3, reg_a[2:0], reg_a[2:0]);
                enc.len = LenW'(3);
            end
            FORM_SHR_I, FORM_SHL_I, FORM_ADD_I8, FORM_CMP_I8:
            begin
                enc.bytes[0] = rex_b(1'b1, 1'b0, 1'b0, reg_a[3]);
                case (form_t'(req_type))
                    FORM_SHR_I:
                    begin
                        enc.bytes[1] = OpShiftI;
                        r = 4'd5;
                    end
                    FORM_SHL_I:
                    begin
                        enc.bytes[1] = OpShiftI;
                        r = 4'd4;
                    end
                    FORM_ADD_I8:
                    begin
                        enc.bytes[1] = OpGrp1I8;
                        r = 4'd0;
                    end
                    default:
                    begin
                        enc.bytes[1] = OpGrp1I8;
                        r = 4'd7;
                    end
                endcase
                enc.bytes[2] = modrm_b(2'd3, r[2:0], reg_a[2:0]);
                enc.bytes[3] = imm[7:0];
                enc.len = LenW'(4);
            end
            FORM_AND_I32:
            begin
                enc.bytes[0]   = rex_b(1'b1, 1'b0, 1'b0, reg_a[3]);
                enc.bytes[1]   = OpGrp1I32;
                enc.bytes[2]   = modrm_b(2'd3, 3'd4, reg_a[2:0]);
                enc.bytes[6:3] = imm[31:0];
                enc.len = LenW'(7);
            end
            FORM_SHL_CL, FORM_SHR_CL, FORM_IDIV, FORM_INC:
            begin
                enc.bytes[0] = rex_b(1'b1, 1'b0, 1'b0, reg_a[3]);
                case (form_t'(req_type))
                    FORM_SHL_CL:
                    begin
                        enc.bytes[1] = OpShiftCl;
                        r = 4'd4;
                    end
                    FORM_SHR_CL:
                    begin
                        enc.bytes[1] = OpShiftCl;
                        r = 4'd5;
                    end
                    FORM_IDIV:
                    begin
                        enc.bytes[1] = 8'hF7;
                        r = 4'd7;
                    end
                    default:
                    begin
                        enc.bytes[1] = OpGrp5;
                        r = 4'd0;
                    end
                endcase
                enc.bytes[2] = modrm_b(2'd3, r[2:0], reg_a[2:0]);
                enc.len = LenW'(3);
            end
            FORM_IMUL:
            begin
                enc.bytes[0] = rex_b(1'b1, reg_a[3], 1'b0, reg_b[3]);
                enc.bytes[1] = OpEsc;
                enc.bytes[2] = OpImul2;
                enc.bytes[3] = modrm_b(2'd3, reg_a[2:0], reg_b[2:0]);
                enc.len = LenW'(4);
            end
            FORM_CQO:
            begin
                enc.bytes[0] = RexW;
                enc.bytes[1] = 8'h99;
                enc.len = LenW'(2);
            end
            FORM_CALL:
            begin
                if (reg_a[3])
                begin
                    enc.bytes[0] = RexB;
                    enc.bytes[1] = OpGrp5;
                    enc.bytes[2] = modrm_b(2'd3, 3'd2, reg_a[2:0]);
                    enc.len = LenW'(3);
                end
                else
                begin
                    enc.bytes[0] = OpGrp5;
                    enc.bytes[1] = modrm_b(2'd3, 3'd2, reg_a[2:0]);
                    enc.len = LenW'(2);
                end
            end
            FORM_RET:
            begin
                enc.bytes[0] = 8'hC3;
                enc.len = LenW'(1);
            end
            FORM_LEAVE:
            begin
                enc.bytes[0] = 8'hC9;
                enc.len = LenW'(1);
            end
            FORM_SUB_RSP, FORM_ADD_RSP:
            begin
                enc.bytes[0]   = RexW;
                enc.bytes[1]   = OpGrp1I32;
                enc.bytes[2]   = (req_type == FORM_SUB_RSP) ? 8'hEC : 8'hC4;
                enc.bytes[6:3] = imm[31:0];
                enc.len = LenW'(7);
            end
            FORM_SYSCALL:
            begin
                enc.bytes[0] = OpEsc;
                enc.bytes[1] = 8'h05;
                enc.len = LenW'(2);
            end
            FORM_JMP:
            begin
                enc.bytes[0]   = OpJmp;
                enc.bytes[4:1] = disp;
                enc.len = LenW'(5);
            end
            FORM_JCOND:
            begin
                enc.bytes[0]   = OpEsc;
                enc.bytes[1]   = {4'h8, cond};
                enc.bytes[5:2] = disp;
                enc.len = LenW'(6);
            end
            FORM_SETCOND:
            begin
                enc.bytes[0] = OpEsc;
                enc.bytes[1] = {4'h9, cond};
                enc.bytes[2] = 8'hC0;
                enc.len = LenW'(3);
            end
            FORM_MOVZX:
            begin
                enc.bytes[0] = OpEsc;
                enc.bytes[1] = 8'hB6;
                enc.bytes[2] = 8'hC0;
                enc.len = LenW'(3);
            end
            FORM_LOAD_B, FORM_STORE_B:
            begin
                // optional REX.B, then opcode, ModRM and maybe the rsp/r12 SIB
                if (base_reg[3])
                begin
                    enc.bytes[0] = RexB;
                    enc.bytes[1] = (req_type == FORM_LOAD_B) ? 8'h8A : 8'h88;
                    enc.bytes[2] = modrm_b(2'd0, 3'd0, base_reg[2:0]);
                    enc.bytes[3] = SibRsp;
                    enc.len = (base_reg[2:0] == 3'd4) ? LenW'(4) : LenW'(3);
                end
                else
                begin
                    enc.bytes[0] = (req_type == FORM_LOAD_B) ? 8'h8A : 8'h88;
                    enc.bytes[1] = modrm_b(2'd0, 3'd0, base_reg[2:0]);
                    enc.bytes[2] = SibRsp;
                    enc.len = (base_reg[2:0] == 3'd4) ? LenW'(3) : LenW'(2);
                end
            end
            default:
            begin
                enc = '0;
            end
        endcase
    end

    assign push      = valid_reg && !qstat.full;
    assign push_item = item_reg;
    assign in_stall  = valid_reg && qstat.full;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (accept)
        begin
            // unknown forms encode to nothing: drop them here
            valid_next = (enc.len != '0);
            item_next  = enc;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// File: hw/rtl/xenc_queue.sv
// Two-entry queue of encoded instructions between front end and back end.
// Depends on xenc_pkg.
module xenc_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  xenc_pkg::xenc_item_t  push_item,
    input  logic                  pop,
    output xenc_pkg::xenc_qstat_t qstat,
    output xenc_pkg::xenc_item_t  head
);
    import xenc_pkg::*;

    xenc_item_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.valid = (count_reg != 2'd0);
    assign head        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (push ? 1'b1 : 1'b0);
        rd_ptr_next = rd_ptr_reg + (pop ? 1'b1 : 1'b0);
        count_next  = count_reg + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/xenc_back.sv
// Back end: streams the bytes of each queued instruction, one per transfer.
// Depends on xenc_pkg.
module xenc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  xenc_pkg::xenc_qstat_t qstat,
    input  xenc_pkg::xenc_item_t  head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            byte_out,
    output logic                  last
);
    import xenc_pkg::*;

    xenc_item_t      cur_reg, cur_next;
    logic            busy_reg, busy_next;
    logic [IdxW-1:0] idx_reg, idx_next;
    logic            ovalid_reg, ovalid_next;
    logic [7:0]      obyte_reg, obyte_next;
    logic            olast_reg, olast_next;
    logic            out_free;
    logic            emit;
    logic            at_end;

    assign out_free = !ovalid_reg || !out_stall;
    assign emit     = busy_reg && out_free;
    assign at_end   = (LenW'(idx_reg) == (cur_reg.len - LenW'(1)));
    // load the next instruction when idle or right as the current one finishes
    assign pop      = qstat.valid && (!busy_reg || (emit && at_end));

    always_comb
    begin
        cur_next    = cur_reg;
        busy_next   = busy_reg;
        idx_next    = idx_reg;
        ovalid_next = ovalid_reg && out_stall;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        if (emit)
        begin
            ovalid_next = 1'b1;
            obyte_next  = cur_reg.bytes[idx_reg];
            olast_next  = at_end;
            idx_next    = idx_reg + IdxW'(1);
            if (at_end)
            begin
                busy_next = 1'b0;
            end
        end
        if (pop)
        begin
            cur_next  = head;
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    assign out_valid = ovalid_reg;
    assign byte_out  = obyte_reg;
    assign last      = olast_reg;

endmodule

// File: hw/rtl/x86_64_instruction_encoder_core.sv
// Top level of the x86-64 instruction encoder.
// Depends on xenc_pkg, xenc_front, xenc_queue and xenc_back.
//
// One request in, its machine-code bytes out, one byte per output transfer with
// last set on the final byte. The output side sustains one byte per cycle while
// out_stall stays low, for instructions of 1 to 10 bytes, and a new request is
// taken whenever the front-end register is empty or the queue has room; the byte
// serializer in the back end sets that rate. The first byte passes through the
// front-end register, the queue write, the serializer load and the output
// register before it is offered. A two-entry queue sits between the encoder and
// the serializer so that either side can stall alone.
// Request kinds 39 to 63 are accepted and produce no bytes.
module x86_64_instruction_encoder_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [5:0]         req_type,
    input  logic [3:0]         reg_a,
    input  logic [3:0]         reg_b,
    input  logic [3:0]         base_reg,
    input  logic [3:0]         index_reg,
    input  logic [3:0]         scale,
    input  logic signed [31:0] disp,
    input  logic [63:0]        imm,
    input  logic [3:0]         cond,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         byte_out,
    output logic               last
);
    import xenc_pkg::*;

    xenc_qstat_t qstat;
    xenc_item_t  push_item;
    xenc_item_t  head;
    logic        push;
    logic        pop;

    xenc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .reg_a     (reg_a),
        .reg_b     (reg_b),
        .base_reg  (base_reg),
        .index_reg (index_reg),
        .scale     (scale),
        .disp      (disp),
        .imm       (imm),
        .cond      (cond),
        .qstat     (qstat),
        .push      (push),
        .push_item (push_item)
    );

    xenc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .qstat     (qstat),
        .head      (head)
    );

    xenc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .byte_out  (byte_out),
        .last      (last)
    );

endmodule
